// File: design/mbg_pkg.sv
`default_nettype none
package mbg_pkg;
  localparam int MAX_DIM = 16;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * COORD_W;
  localparam int CELL_COUNT = MAX_DIM * MAX_DIM;
  localparam int LEVEL_W = ADDR_W + 1;
  localparam int DIM_W = 5;
  localparam int CELL_W = 5;

  localparam logic [CELL_W-1:0] OPEN_N = 5'h01;
  localparam logic [CELL_W-1:0] OPEN_E = 5'h02;
  localparam logic [CELL_W-1:0] OPEN_S = 5'h04;
  localparam logic [CELL_W-1:0] OPEN_W = 5'h08;
  localparam logic [CELL_W-1:0] MARK_VISITED = 5'h10;

  localparam logic [1:0] FUNC_RESTART = 2'd0;
  localparam logic [1:0] FUNC_STEP = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [2:0] ST_CARVED = 3'd0;
  localparam logic [2:0] ST_BACK = 3'd1;
  localparam logic [2:0] ST_NOCHG = 3'd2;
  localparam logic [2:0] ST_RESTART = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // cell-store address select
  typedef enum logic [2:0] {
    CA_TOP, CA_NORTH, CA_EAST, CA_SOUTH, CA_WEST, CA_NEXT, CA_READ, CA_CLEAR
  } caddr_sel_t;

  typedef struct packed {
    logic       load_item;
    logic       clr_start;
    logic       clr_adv;
    logic       reset_path;
    caddr_sel_t csel;
    logic [1:0] nb_slot;
    logic       nb_capture;
    logic       stk_rd;
    logic       top_capture;
    logic       decide;
    logic       wr_top;
    logic       wr_next;
    logic       wr_clear;
    logic       push;
    logic       pop;
    logic       read_capture;
    logic       out_load;
    logic [2:0] out_status;
  } mbg_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       stack_ok;
    logic       finished;
    logic       has_cand;
    logic [1:0] func;
  } mbg_sts_t;
endpackage
`default_nettype wire

// File: design/mbg_ram.sv
`default_nettype none
module mbg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/mbg_datapath.sv
`default_nettype none
module mbg_datapath import mbg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mbg_cmd_t            cmd,
  output mbg_sts_t                 sts,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [DIM_W-1:0]    cfg_data,
  input  wire logic [1:0]          in_func,
  input  wire logic [15:0]         in_rand_value,
  input  wire logic [3:0]          in_read_col,
  input  wire logic [3:0]          in_read_row,
  output logic [2:0]               out_status,
  output logic [3:0]               out_cur_col,
  output logic [3:0]               out_cur_row,
  output logic [4:0]               out_cell_bits,
  output logic [8:0]               out_visited_count,
  output logic                     out_done_res
);
  logic [DIM_W-1:0] width_r, height_r;
  logic [1:0] func_r;
  logic [15:0] rand_r;
  logic [3:0] rcol_r, rrow_r;
  logic [ADDR_W-1:0] clr_r, top_r, next_r;
  logic [LEVEL_W-1:0] level_r;
  logic [8:0] visited_r;
  logic [3:0] cand_r;
  logic [ADDR_W-1:0] top_cur_r;
  logic [4:0] rbits_r;
  logic [CELL_W-1:0] here_bit_r, there_bit_r;

  logic [COORD_W:0] w_use, h_use;
  logic [COORD_W-1:0] tcol, trow;
  logic [ADDR_W-1:0] caddr, cwaddr, saddr;
  logic [CELL_W-1:0] crdata, cwdata;
  logic cwe;
  logic [ADDR_W-1:0] srdata;
  logic [9:0] area;
  logic finished;

  function automatic logic [COORD_W:0] dim_use(input logic [DIM_W-1:0] v);
    if (v == '0) return (COORD_W+1)'(1);
    if (32'(v) > MAX_DIM) return (COORD_W+1)'(MAX_DIM);
    return (COORD_W+1)'(v);
  endfunction

  assign w_use = dim_use(width_r);
  assign h_use = dim_use(height_r);
  assign area = 10'(w_use) * 10'(h_use);
  assign finished = 10'(visited_r) >= area;
  assign tcol = top_r[COORD_W-1:0];
  assign trow = top_r[ADDR_W-1:COORD_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DIM_W'(15);
      height_r <= DIM_W'(15);
    end else if (cfg_we) begin
      if (cfg_index == {1'b0, CFG_WIDTH}) width_r <= cfg_data;
      else if (cfg_index == {1'b0, CFG_HEIGHT}) height_r <= cfg_data;
    end
  end

  always_comb begin
    unique case (cmd.csel)
      CA_TOP:   caddr = top_r;
      CA_NORTH: caddr = top_r - ADDR_W'(MAX_DIM);
      CA_EAST:  caddr = top_r + ADDR_W'(1);
      CA_SOUTH: caddr = top_r + ADDR_W'(MAX_DIM);
      CA_WEST:  caddr = top_r - ADDR_W'(1);
      CA_NEXT:  caddr = next_r;
      CA_READ:  caddr = {rrow_r, rcol_r};
      CA_CLEAR: caddr = clr_r;
      default:  caddr = top_r;
    endcase
  end

  // write data: clear pass, or OR a wall bit into the word read last cycle
  always_comb begin
    cwe = cmd.wr_clear | cmd.wr_top | cmd.wr_next;
    cwaddr = cmd.wr_clear ? clr_r : (cmd.wr_top ? top_r : next_r);
    if (cmd.wr_clear) cwdata = (clr_r == '0) ? MARK_VISITED : '0;
    else if (cmd.wr_top) cwdata = crdata | here_bit_r;
    else cwdata = crdata | there_bit_r | MARK_VISITED;
  end

  mbg_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_cells (
    .clk(clk), .we(cwe), .waddr(cwaddr), .wdata(cwdata),
    .raddr(caddr), .rdata(crdata)
  );

  assign saddr = level_r[ADDR_W-1:0] - ADDR_W'(1);

  mbg_ram #(.WIDTH(ADDR_W), .DEPTH(CELL_COUNT)) u_stack (
    .clk(clk), .we(cmd.push | cmd.reset_path),
    .waddr(cmd.reset_path ? ADDR_W'(0) : level_r[ADDR_W-1:0]),
    .wdata(cmd.reset_path ? ADDR_W'(0) : next_r),
    .raddr(saddr), .rdata(srdata)
  );

  logic [3:0] cnt;
  logic [1:0] idx;
  logic [3:0] m;
  logic [1:0] sel;
  logic [1:0] seen;
  logic [31:0] rprod;
  logic [14:0] rq3;
  logic [15:0] rq3x3;
  logic [1:0] rrem3;

  // candidate count and pick by rand mod count (count at most four)
  always_comb begin
    cnt = 4'(cand_r[0]) + 4'(cand_r[1]) + 4'(cand_r[2]) + 4'(cand_r[3]);
    // divide by three with a reciprocal multiply, exact for 16-bit inputs
    rprod = 32'(rand_r) * 32'd43691;
    rq3 = rprod[31:17];
    rq3x3 = {rq3, 1'b0} + {1'b0, rq3};
    rrem3 = 2'(rand_r - rq3x3);
    unique case (cnt)
      4'd1: idx = 2'd0;
      4'd2: idx = {1'b0, rand_r[0]};
      4'd3: idx = rrem3;
      default: idx = rand_r[1:0];
    endcase
    sel = 2'd0;
    seen = 2'd0;
    m = cand_r;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        if (seen == idx) sel = 2'(i);
        seen = seen + 2'd1;
      end
    end
  end

  logic nb_ok;
  always_comb begin
    unique case (cmd.nb_slot)
      2'd0: nb_ok = trow != '0;
      2'd1: nb_ok = ({1'b0, tcol} + (COORD_W+1)'(1)) < w_use;
      2'd2: nb_ok = ({1'b0, trow} + (COORD_W+1)'(1)) < h_use;
      default: nb_ok = tcol != '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LEVEL_W'(1);
      visited_r <= 9'd1;
      top_cur_r <= '0;
      clr_r <= '0;
      cand_r <= '0;
    end else begin
      if (cmd.clr_start) clr_r <= '0;
      else if (cmd.clr_adv) clr_r <= clr_r + ADDR_W'(1);
      if (cmd.reset_path) begin
        level_r <= LEVEL_W'(1);
        visited_r <= 9'd1;
        top_cur_r <= '0;
      end
      if (cmd.nb_capture) cand_r[cmd.nb_slot] <= nb_ok & ~crdata[4];
      if (cmd.top_capture) cand_r <= '0;
      if (cmd.push) begin
        if (32'(level_r) < CELL_COUNT) begin
          level_r <= level_r + LEVEL_W'(1);
          top_cur_r <= next_r;
        end
        visited_r <= visited_r + 9'd1;
      end
      if (cmd.pop) level_r <= level_r - LEVEL_W'(1);
      if (cmd.stk_rd) top_cur_r <= srdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r <= in_func;
      rand_r <= in_rand_value;
      rcol_r <= in_read_col;
      rrow_r <= in_read_row;
    end
    if (cmd.top_capture) top_r <= srdata;
    if (cmd.decide) begin
      unique case (sel)
        2'd0: begin next_r <= top_r - ADDR_W'(MAX_DIM); here_bit_r <= OPEN_N;
          there_bit_r <= OPEN_S; end
        2'd1: begin next_r <= top_r + ADDR_W'(1); here_bit_r <= OPEN_E;
          there_bit_r <= OPEN_W; end
        2'd2: begin next_r <= top_r + ADDR_W'(MAX_DIM); here_bit_r <= OPEN_S;
          there_bit_r <= OPEN_N; end
        default: begin next_r <= top_r - ADDR_W'(1); here_bit_r <= OPEN_W;
          there_bit_r <= OPEN_E; end
      endcase
    end
    if (cmd.read_capture) rbits_r <= crdata;
  end

  logic stack_ok;
  assign stack_ok = (level_r != '0) && (32'(level_r) <= CELL_COUNT);

  always_comb begin
    sts.clr_last = clr_r == ADDR_W'(CELL_COUNT - 1);
    sts.stack_ok = stack_ok;
    sts.finished = finished;
    sts.has_cand = cand_r != '0;
    sts.func = func_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      out_cur_col <= stack_ok ? top_cur_r[COORD_W-1:0] : '0;
      out_cur_row <= stack_ok ? top_cur_r[ADDR_W-1:COORD_W] : '0;
      out_cell_bits <= (cmd.out_status == ST_READ) ? rbits_r : '0;
      out_visited_count <= visited_r;
      out_done_res <= finished;
    end
  end
endmodule
`default_nettype wire

// File: design/mbg_ctrl.sv
`default_nettype none
module mbg_ctrl import mbg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire mbg_sts_t sts,
  output mbg_cmd_t      cmd
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_CLEAR, S_TOP, S_NB, S_DECIDE, S_WTOP, S_RNEXT,
    S_WNEXT, S_STKRD, S_READ, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [2:0] status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd = '0;
    cmd.csel = CA_TOP;
    state_nxt = state_r;
    slot_nxt = slot_r;
    status_nxt = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_INIT: begin
        // clear the cells and seed the path with cell zero
        cmd.csel = CA_CLEAR;
        cmd.wr_clear = 1'b1;
        cmd.clr_adv = 1'b1;
        cmd.reset_path = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        cmd.load_item = 1'b1;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (sts.func == FUNC_RESTART) begin
          cmd.clr_start = 1'b1;
          cmd.reset_path = 1'b1;
          status_nxt = ST_RESTART;
          state_nxt = S_CLEAR;
        end else if (sts.func == FUNC_STEP) begin
          if (sts.finished || !sts.stack_ok) begin
            status_nxt = ST_NOCHG;
            state_nxt = S_OUT;
          end else begin
            cmd.stk_rd = 1'b0;
            state_nxt = S_TOP;
          end
        end else if (sts.func == FUNC_READ) begin
          cmd.csel = CA_READ;
          status_nxt = ST_READ;
          state_nxt = S_READ;
        end else begin
          status_nxt = ST_NOCHG;
          state_nxt = S_OUT;
        end
      end
      S_CLEAR: begin
        cmd.csel = CA_CLEAR;
        cmd.wr_clear = 1'b1;
        cmd.clr_adv = 1'b1;
        if (sts.clr_last) state_nxt = S_OUT;
      end
      S_TOP: begin
        // stack read data (top) is ready now
        cmd.top_capture = 1'b1;
        slot_nxt = 2'd0;
        state_nxt = S_NB;
      end
      S_NB: begin
        // issue read of slot; S_DECIDE captures it from the cell RAM
        unique case (slot_r)
          2'd0: cmd.csel = CA_NORTH;
          2'd1: cmd.csel = CA_EAST;
          2'd2: cmd.csel = CA_SOUTH;
          default: cmd.csel = CA_WEST;
        endcase
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.nb_slot = slot_r;
        cmd.nb_capture = 1'b1;
        if (slot_r != 2'd3) begin
          slot_nxt = slot_r + 2'd1;
          state_nxt = S_NB;
        end else begin
          state_nxt = S_WTOP;
          slot_nxt = 2'd0;
        end
      end
      S_WTOP: begin
        if (!sts.has_cand) begin
          cmd.pop = 1'b1;
          status_nxt = ST_BACK;
          state_nxt = S_STKRD;
        end else if (slot_r == 2'd0) begin
          cmd.decide = 1'b1;
          cmd.csel = CA_TOP;
          slot_nxt = 2'd1;
        end else begin
          cmd.wr_top = 1'b1;
          cmd.csel = CA_NEXT;
          state_nxt = S_WNEXT;
        end
      end
      S_WNEXT: begin
        cmd.wr_next = 1'b1;
        cmd.push = 1'b1;
        status_nxt = ST_CARVED;
        state_nxt = S_OUT;
      end
      S_STKRD: begin
        // stack port now addresses new top; data is ready next cycle
        state_nxt = S_RNEXT;
      end
      S_RNEXT: begin
        cmd.stk_rd = sts.stack_ok;
        state_nxt = S_OUT;
      end
      S_READ: begin
        cmd.read_capture = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_free) begin
        cmd.out_load = 1'b1;
        cmd.out_status = status_r;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      slot_r <= '0;
      status_r <= ST_NOCHG;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
      status_r <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: design/maze_backtracker_generator.sv
`default_nettype none
// Depth-first maze carver over a grid of up to 16x16 cells held in one cell RAM
// and one path-stack RAM. After reset, a clearing pass over all 256 cells runs
// before the first item is taken; a restart item repeats it. A carve step reads
// the four neighbors in turn through the single cell-RAM read port, then updates
// two cells in turn; a backtrack pops the path stack. One result per item; the
// next item is taken once the result is in the output register.
module maze_backtracker_generator import mbg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_rand_value,
  input  wire logic [3:0]  in_read_col,
  input  wire logic [3:0]  in_read_row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [3:0]       out_cur_col,
  output logic [3:0]       out_cur_row,
  output logic [4:0]       out_cell_bits,
  output logic [8:0]       out_visited_count,
  output logic             out_done_res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [4:0]  cfg_data
);
  mbg_cmd_t cmd;
  mbg_sts_t sts;

  mbg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  mbg_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_func(in_func), .in_rand_value(in_rand_value),
    .in_read_col(in_read_col), .in_read_row(in_read_row),
    .out_status(out_status), .out_cur_col(out_cur_col), .out_cur_row(out_cur_row),
    .out_cell_bits(out_cell_bits), .out_visited_count(out_visited_count),
    .out_done_res(out_done_res)
  );
endmodule
`default_nettype wire

// File: design/mbg_checker.sv
`default_nettype none
module mbg_checker import mbg_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [4:0] out_cell_bits,
  input wire logic [8:0] out_visited_count
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");
  a_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_READ |-> out_cell_bits == '0)
    else $error("cell bits outside read");
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_RESTART |-> out_visited_count == 9'd1)
    else $error("restart count wrong");
endmodule

bind maze_backtracker_generator mbg_checker u_mbg_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_cell_bits(out_cell_bits), .out_visited_count(out_visited_count)
);
`default_nettype wire
